[rtl/cmbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbr_pkg
// Shared constants, codes and structs of the backward camera model pipeline.
// ----------------------------------------------------------------------------
package cmbr_pkg;

    // Fixed-point format and table sizes
    localparam int FRAC_BITS    = 20;
    localparam int OUT_SHIFT    = FRAC_BITS - 8;
    localparam int MAX_POINTS   = 4096;
    localparam int PT_AW        = $clog2(MAX_POINTS);
    localparam int PT_CW        = PT_AW + 1;
    localparam int TONE_ENTRIES = 256;
    localparam int TONE_AW      = $clog2(TONE_ENTRIES);
    localparam int COEF_ROWS    = 4;
    localparam int MAT_ROWS     = 3;
    localparam int SQRT_STEPS   = 32;
    localparam int SQRT_CW      = $clog2(SQRT_STEPS);

    // Beat commands
    typedef enum logic [2:0] {
        CMD_PIXEL  = 3'd0,
        CMD_POINT  = 3'd1,
        CMD_WEIGHT = 3'd2,
        CMD_TONE   = 3'd3,
        CMD_COEF   = 3'd4,
        CMD_MATRIX = 3'd5
    } cmd_t;

    // Table write request
    typedef struct packed {
        logic        en;
        logic [2:0]  cmd;
        logic [11:0] idx;
        logic [1:0]  ch;
        logic [31:0] value;
    } tbl_wr_t;

    // Product waiting to be accumulated
    typedef struct packed {
        logic       valid;
        logic       to_sq;
        logic [1:0] col;
    } pend_t;

endpackage

[rtl/cmbr_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbr_mul
// Shared signed 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module cmbr_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    // Register the product every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[rtl/cmbr_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbr_sqrt
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module cmbr_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic        done,
    output logic [31:0] root
);

    logic                         busy_reg;
    logic [cmbr_pkg::SQRT_CW-1:0] cnt_reg;
    logic [63:0]                  v_reg;
    logic [63:0]                  r_reg;
    logic [63:0]                  bit_reg;
    logic [63:0]                  trial;
    logic                         take;

    assign trial = r_reg + bit_reg;
    assign take  = (v_reg >= trial);

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == cmbr_pkg::SQRT_CW'(cmbr_pkg::SQRT_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Restoring root step: subtract trial where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (cnt_reg == cmbr_pkg::SQRT_CW'(cmbr_pkg::SQRT_STEPS - 1));
    assign root = r_reg[31:0];

endmodule

[rtl/cmbr_tables.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmbr_tables
// Model tables: control points, weights and tone curve, one memory per colour
// component, plus register files for the linear coefficients and colour matrix.
// ----------------------------------------------------------------------------
module cmbr_tables (
    input  logic                           clk,
    input  cmbr_pkg::tbl_wr_t              wr,
    input  logic [cmbr_pkg::TONE_AW-1:0]   tone_addr [3],
    input  logic [cmbr_pkg::PT_AW-1:0]     pt_addr,
    input  logic [3:0]                     coef_idx,
    input  logic [3:0]                     mat_idx,
    output logic signed [31:0]             tone_q [3],
    output logic signed [31:0]             cp_q [3],
    output logic signed [31:0]             w_q [3],
    output logic signed [31:0]             bias_q [3],
    output logic signed [31:0]             coef_q,
    output logic signed [31:0]             mat_q
);

    logic signed [31:0] coef_mem [cmbr_pkg::COEF_ROWS * 3];
    logic signed [31:0] mat_mem [cmbr_pkg::MAT_ROWS * 3];
    logic               cp_we;
    logic               w_we;
    logic               tone_we;
    logic               coef_we;
    logic               mat_we;
    logic [3:0]         small_addr;

    // Decode load beats, dropping out-of-range rows and channel 3
    always_comb
    begin
        cp_we   = wr.en && (wr.cmd == cmbr_pkg::CMD_POINT)
                  && ({1'b0, wr.idx} < 13'(cmbr_pkg::MAX_POINTS));
        w_we    = wr.en && (wr.cmd == cmbr_pkg::CMD_WEIGHT)
                  && ({1'b0, wr.idx} < 13'(cmbr_pkg::MAX_POINTS));
        tone_we = wr.en && (wr.cmd == cmbr_pkg::CMD_TONE)
                  && ({1'b0, wr.idx} < 13'(cmbr_pkg::TONE_ENTRIES));
        coef_we = wr.en && (wr.cmd == cmbr_pkg::CMD_COEF)
                  && (wr.idx < 12'(cmbr_pkg::COEF_ROWS)) && (wr.ch != 2'd3);
        mat_we  = wr.en && (wr.cmd == cmbr_pkg::CMD_MATRIX)
                  && (wr.idx < 12'(cmbr_pkg::MAT_ROWS)) && (wr.ch != 2'd3);
        small_addr = ({2'b00, wr.idx[1:0]} << 1) + {2'b00, wr.idx[1:0]} + {2'b00, wr.ch};
    end

    // Per-component memories, registered reads
    for (genvar g = 0; g < 3; g++)
    begin : g_ch
        logic signed [31:0] cp_mem [cmbr_pkg::MAX_POINTS];
        logic signed [31:0] w_mem [cmbr_pkg::MAX_POINTS];
        logic signed [31:0] tone_mem [cmbr_pkg::TONE_ENTRIES];

        always_ff @(posedge clk)
        begin
            if (cp_we && (wr.ch == 2'(g)))
            begin
                cp_mem[wr.idx[cmbr_pkg::PT_AW-1:0]] <= wr.value;
            end
            cp_q[g] <= cp_mem[pt_addr];
        end

        always_ff @(posedge clk)
        begin
            if (w_we && (wr.ch == 2'(g)))
            begin
                w_mem[wr.idx[cmbr_pkg::PT_AW-1:0]] <= wr.value;
            end
            w_q[g] <= w_mem[pt_addr];
        end

        always_ff @(posedge clk)
        begin
            if (tone_we && (wr.ch == 2'(g)))
            begin
                tone_mem[wr.idx[cmbr_pkg::TONE_AW-1:0]] <= wr.value;
            end
            tone_q[g] <= tone_mem[tone_addr[g]];
        end

        assign bias_q[g] = coef_mem[g];
    end

    // Small coefficient and matrix register files
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[small_addr] <= wr.value;
        end
        if (mat_we)
        begin
            mat_mem[small_addr] <= wr.value;
        end
    end

    assign coef_q = coef_mem[coef_idx];
    assign mat_q  = mat_mem[mat_idx];

endmodule

[rtl/camera_model_backward_rbf_pipeline.sv]
`timescale 1ns / 1ps
// Sequencing: for a pixel beat, each control point costs a table read,
//   three squares, a square root and three weight products through one
//   shared multiplier.
// Flow: one pixel at a time; load beats are taken only while the sequencer is idle.
// Reset: rst_n clears the sequencer and output valid, points_in_use -> 4096;
//   table contents stay undefined until written.
// ----------------------------------------------------------------------------
// camera_model_backward_rbf_pipeline
// Backward camera model: reverse tone curve, radial basis gamut map and
// inverse colour matrix, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
module camera_model_backward_rbf_pipeline (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,        // points_in_use
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[11:0], channel[13:12], table_value[45:14],
    // red_in[53:46], green_in[61:54], blue_in[69:62], zero pad[71:70]
    input  logic [71:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,     // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata      // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_TONE    = 14'b00000000000010,
        ST_PT_RD   = 14'b00000000000100,
        ST_PT_DIFF = 14'b00000000001000,
        ST_SQ      = 14'b00000000010000,
        ST_SQ_END  = 14'b00000000100000,
        ST_SQRT    = 14'b00000001000000,
        ST_WMUL    = 14'b00000010000000,
        ST_LIN     = 14'b00000100000000,
        ST_LIN_END = 14'b00001000000000,
        ST_CLAMP   = 14'b00010000000000,
        ST_MAT     = 14'b00100000000000,
        ST_MAT_END = 14'b01000000000000,
        ST_OUT     = 14'b10000000000000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [12:0]                     points_reg;
    logic [cmbr_pkg::PT_CW-1:0]      n_reg;
    logic [cmbr_pkg::PT_CW-1:0]      pt_cnt_reg;
    logic [1:0]                      col_reg;
    logic [1:0]                      row_reg;
    cmbr_pkg::pend_t                 pend_reg;
    logic signed [31:0]              tone_reg [3];
    logic [31:0]                     mag_reg [3];
    logic signed [31:0]              w_reg [3];
    logic [63:0]                     sq_reg;
    logic signed [63:0]              acc_reg [3];
    logic [30:0]                     r_reg [3];
    logic                            out_valid_reg;
    logic [23:0]                     out_data_reg;

    logic                            accept;
    logic                            issue;
    logic                            last_issue;
    logic                            last_point;
    logic                            out_load;
    cmbr_pkg::tbl_wr_t               wr;
    logic [cmbr_pkg::TONE_AW-1:0]    tone_addr [3];
    logic signed [31:0]              tone_q [3];
    logic signed [31:0]              cp_q [3];
    logic signed [31:0]              w_q [3];
    logic signed [31:0]              bias_q [3];
    logic signed [31:0]              coef_q;
    logic signed [31:0]              mat_q;
    logic [3:0]                      coef_idx;
    logic [3:0]                      mat_idx;
    logic signed [32:0]              mul_a;
    logic signed [32:0]              mul_b;
    logic signed [65:0]              prod;
    logic signed [65:0]              prod_shr;
    logic                            sqrt_start;
    logic                            sqrt_busy;
    logic                            sqrt_done;
    logic [31:0]                     sq_root;
    logic [63:0]                     sq_total;
    logic [31:0]                     mag_next [3];
    logic [30:0]                     r_next [3];
    logic [7:0]                      byte_next [3];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Table write request from load beats
    always_comb
    begin
        wr.en    = accept && (s_axis_tuser != cmbr_pkg::CMD_PIXEL);
        wr.cmd   = s_axis_tuser;
        wr.idx   = s_axis_tdata[11:0];
        wr.ch    = s_axis_tdata[13:12];
        wr.value = s_axis_tdata[45:14];
        tone_addr[0] = s_axis_tdata[53:46];
        tone_addr[1] = s_axis_tdata[61:54];
        tone_addr[2] = s_axis_tdata[69:62];
    end

    cmbr_tables u_tables (
        .clk       (clk),
        .wr        (wr),
        .tone_addr (tone_addr),
        .pt_addr   (pt_cnt_reg[cmbr_pkg::PT_AW-1:0]),
        .coef_idx  (coef_idx),
        .mat_idx   (mat_idx),
        .tone_q    (tone_q),
        .cp_q      (cp_q),
        .w_q       (w_q),
        .bias_q    (bias_q),
        .coef_q    (coef_q),
        .mat_q     (mat_q)
    );

    cmbr_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Fold the last square, still in the multiplier register, into the radicand
    assign sq_total = sq_reg + prod[63:0];

    cmbr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_total),
        .busy     (sqrt_busy),
        .done     (sqrt_done),
        .root     (sq_root)
    );

    assign sqrt_start = (state_reg == ST_SQ_END);
    assign prod_shr   = prod >>> cmbr_pkg::FRAC_BITS;
    assign issue      = (state_reg == ST_SQ) || (state_reg == ST_WMUL)
                        || (state_reg == ST_LIN) || (state_reg == ST_MAT);
    assign last_issue = (col_reg == 2'd2)
                        && ((state_reg == ST_SQ) || (state_reg == ST_WMUL) || (row_reg == 2'd2));
    assign last_point = ((pt_cnt_reg + 1'b1) == n_reg);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        coef_idx = '0;
        mat_idx  = '0;
        case (state_reg)
            ST_SQ:
            begin
                mul_a = {1'b0, mag_reg[col_reg]};
                mul_b = {1'b0, mag_reg[col_reg]};
            end
            ST_WMUL:
            begin
                mul_a = {w_reg[col_reg][31], w_reg[col_reg]};
                mul_b = {1'b0, sq_root};
            end
            ST_LIN:
            begin
                coef_idx = ({2'b00, row_reg} << 1) + {2'b00, row_reg} + {2'b00, col_reg} + 4'd3;
                mul_a    = {coef_q[31], coef_q};
                mul_b    = {tone_reg[row_reg][31], tone_reg[row_reg]};
            end
            ST_MAT:
            begin
                mat_idx = ({2'b00, row_reg} << 1) + {2'b00, row_reg} + {2'b00, col_reg};
                mul_a   = {2'b00, r_reg[row_reg]};
                mul_b   = {mat_q[31], mat_q};
            end
            default:
            begin
            end
        endcase
    end

    // Saturated distance magnitudes, affine clamp and output bytes
    always_comb
    begin
        logic signed [32:0] diff;
        logic signed [63:0] lin;
        logic signed [63:0] mv;
        for (int c = 0; c < 3; c++)
        begin
            diff = {tone_reg[c][31], tone_reg[c]} - {cp_q[c][31], cp_q[c]};
            if (!diff[32])
            begin
                mag_next[c] = diff[31] ? 32'h7FFF_FFFF : diff[31:0];
            end
            else
            begin
                mag_next[c] = (diff < -33'sd2147483648) ? 32'h8000_0000 : 32'(-diff);
            end
            lin = acc_reg[c] + {{32{bias_q[c][31]}}, bias_q[c]};
            if (lin[63])
            begin
                r_next[c] = '0;
            end
            else if (|lin[62:31])
            begin
                r_next[c] = '1;
            end
            else
            begin
                r_next[c] = lin[30:0];
            end
            mv = acc_reg[c];
            if (mv[63])
            begin
                byte_next[c] = '0;
            end
            else if (|mv[62:cmbr_pkg::FRAC_BITS])
            begin
                byte_next[c] = 8'hFF;
            end
            else
            begin
                byte_next[c] = mv[cmbr_pkg::FRAC_BITS-1:cmbr_pkg::OUT_SHIFT];
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == cmbr_pkg::CMD_PIXEL))
                begin
                    state_next = ST_TONE;
                end
            end
            ST_TONE:
            begin
                state_next = (n_reg == '0) ? ST_LIN : ST_PT_RD;
            end
            ST_PT_RD:   state_next = ST_PT_DIFF;
            ST_PT_DIFF: state_next = ST_SQ;
            ST_SQ:
            begin
                if (last_issue)
                begin
                    state_next = ST_SQ_END;
                end
            end
            ST_SQ_END:  state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_WMUL;
                end
            end
            ST_WMUL:
            begin
                if (last_issue)
                begin
                    state_next = last_point ? ST_LIN : ST_PT_RD;
                end
            end
            ST_LIN:
            begin
                if (last_issue)
                begin
                    state_next = ST_LIN_END;
                end
            end
            ST_LIN_END: state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_MAT;
            ST_MAT:
            begin
                if (last_issue)
                begin
                    state_next = ST_MAT_END;
                end
            end
            ST_MAT_END: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            points_reg    <= 13'(cmbr_pkg::MAX_POINTS);
            col_reg       <= '0;
            row_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                points_reg <= cfg_wdata;
            end
            // Advance the issue counters across a product run
            if (issue)
            begin
                if (last_issue)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (col_reg == 2'd2)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            pend_reg.valid <= issue;
            pend_reg.to_sq <= (state_reg == ST_SQ);
            pend_reg.col   <= col_reg;
            // Hold the result until the beat is taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg      <= (points_reg > 13'(cmbr_pkg::MAX_POINTS))
                          ? cmbr_pkg::PT_CW'(cmbr_pkg::MAX_POINTS)
                          : cmbr_pkg::PT_CW'(points_reg);
            pt_cnt_reg <= '0;
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        if (state_reg == ST_TONE)
        begin
            tone_reg <= tone_q;
        end
        if (state_reg == ST_PT_DIFF)
        begin
            mag_reg <= mag_next;
            w_reg   <= w_q;
            sq_reg  <= '0;
        end
        if ((state_reg == ST_WMUL) && last_issue && !last_point)
        begin
            pt_cnt_reg <= pt_cnt_reg + 1'b1;
        end
        // Accumulate the product issued last cycle
        if (pend_reg.valid)
        begin
            if (pend_reg.to_sq)
            begin
                sq_reg <= sq_reg + prod[63:0];
            end
            else
            begin
                acc_reg[pend_reg.col] <= acc_reg[pend_reg.col] + $signed(prod_shr[63:0]);
            end
        end
        // Add bias, clamp and clear for the matrix pass
        if (state_reg == ST_CLAMP)
        begin
            r_reg <= r_next;
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= '0;
            end
        end
        if (out_load)
        begin
            out_data_reg <= {byte_next[2], byte_next[1], byte_next[0]};
        end
    end

    // Products are accumulated only the cycle after they were issued
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg.valid |-> $past(issue))
        else $error("accumulate without an issued product");

    // The root unit runs for the whole root phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> sqrt_busy)
        else $error("root phase without a busy root unit");

    // The point counter stays inside the points in use
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PT_RD) || (state_reg == ST_PT_DIFF) || (state_reg == ST_SQ)
         || (state_reg == ST_WMUL)) |-> (pt_cnt_reg < n_reg))
        else $error("point counter beyond points in use");

    // A result appears only from the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result beat without output step");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the backward camera model pipeline. Every table
// entry that a pixel can reach is loaded first, so no pixel reads an unwritten
// entry. A directed set of beats covers field extremes, ignored loads and
// clamping. Random load and pixel beats follow under several point counts.
// Results are checked against a bit-exact fixed-point model or a typed value.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] CMD_RSVD_A  = 3'd6;
    localparam logic [2:0] CMD_RSVD_B  = 3'd7;
    localparam longint     I32_MAX     = 64'sh7FFFFFFF;
    localparam longint     I32_MIN     = -64'sh80000000;
    localparam longint     CYCLE_CAP   = 3000000;
    localparam int         DIR_ROWS    = 26;
    localparam int         PHASES      = 4;
    localparam int         PHASE_BEATS = 10;
    localparam int         FILL_POINTS = 6;
    localparam int         TONE_PICKS  = 6;
    localparam logic [7:0] TONE_PICK [TONE_PICKS] = '{8'h00, 8'h01, 8'h3C, 8'h5A,
                                                      8'h81, 8'hFF};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] idx;
        logic [1:0]  ch;
        logic [31:0] val;
        logic [23:0] pix;     // red[7:0], green[15:8], blue[23:16]
        logic        typed;
        logic [23:0] typed_out;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // model state
    int          pt_tab   [cmbr_pkg::MAX_POINTS*3];
    int          wt_tab   [cmbr_pkg::MAX_POINTS*3];
    int          tone_tab [cmbr_pkg::TONE_ENTRIES*3];
    int          coef_tab [12];
    int          mat_tab  [9];
    int unsigned pts_cfg;

    logic [23:0] pending_pixels [$];
    int          err_count;
    longint      cycles;
    int          burst_left;
    int          hold_asked;
    int          hold_done;
    int          hold_left;
    int          pat_cnt;
    dir_row_t    dir_rows [DIR_ROWS];

    camera_model_backward_rbf_pipeline uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Backward mapping of one pixel: tone curve, radial sum, affine, matrix
    function automatic logic [23:0] backward_map(input logic [23:0] pix);
        longint          tn [3];
        longint          acc [3];
        longint          v;
        longint          d;
        longint          rad;
        longint unsigned sq;
        longint unsigned m;
        int              n;
        logic [23:0]     res;
        for (int c = 0; c < 3; c++)
        begin
            tn[c]  = tone_tab[int'(pix[c*8 +: 8]) * 3 + c];
            acc[c] = 0;
        end
        n = (pts_cfg > cmbr_pkg::MAX_POINTS) ? cmbr_pkg::MAX_POINTS : pts_cfg;
        for (int p = 0; p < n; p++)
        begin
            sq = 0;
            for (int k = 0; k < 3; k++)
            begin
                d = tn[k] - longint'(pt_tab[p*3 + k]);
                if (d > I32_MAX) d = I32_MAX;
                if (d < I32_MIN) d = I32_MIN;
                m  = (d < 0) ? -d : d;
                sq = sq + m * m;
            end
            rad = longint'(floor_root(sq));
            for (int c = 0; c < 3; c++)
                acc[c] = acc[c] + ((longint'(wt_tab[p*3 + c]) * rad) >>> cmbr_pkg::FRAC_BITS);
        end
        for (int c = 0; c < 3; c++)
        begin
            v = acc[c] + longint'(coef_tab[c]);
            for (int k = 0; k < 3; k++)
                v = v + ((longint'(coef_tab[(k+1)*3 + c]) * tn[k]) >>> cmbr_pkg::FRAC_BITS);
            if (v < 0) v = 0;
            if (v > I32_MAX) v = I32_MAX;
            acc[c] = v;
        end
        for (int c = 0; c < 3; c++)
        begin
            v = 0;
            for (int k = 0; k < 3; k++)
                v = v + ((acc[k] * longint'(mat_tab[k*3 + c])) >>> cmbr_pkg::FRAC_BITS);
            if (v < 0) v = 0;
            v = v >>> cmbr_pkg::OUT_SHIFT;
            if (v > 255) v = 255;
            res[c*8 +: 8] = v[7:0];
        end
        return res;
    endfunction

    // Table write as the block applies it; out-of-range loads fall through
    function automatic void table_write(input logic [2:0] cmd, input logic [11:0] idx,
                                        input logic [1:0] ch, input logic [31:0] val);
        int a;
        if (ch > 2)
            return;
        a = int'(idx) * 3 + int'(ch);
        case (cmd)
            cmbr_pkg::CMD_POINT:
                if (idx < cmbr_pkg::MAX_POINTS)   pt_tab[a]   = $signed(val);
            cmbr_pkg::CMD_WEIGHT:
                if (idx < cmbr_pkg::MAX_POINTS)   wt_tab[a]   = $signed(val);
            cmbr_pkg::CMD_TONE:
                if (idx < cmbr_pkg::TONE_ENTRIES) tone_tab[a] = $signed(val);
            cmbr_pkg::CMD_COEF:
                if (idx < cmbr_pkg::COEF_ROWS)    coef_tab[a] = $signed(val);
            cmbr_pkg::CMD_MATRIX:
                if (idx < cmbr_pkg::MAT_ROWS)     mat_tab[a]  = $signed(val);
            default: ;
        endcase
    endfunction

    // Pixel built from bytes whose tone entries are loaded
    function automatic logic [23:0] pick_pixel();
        logic [23:0] p;
        for (int c = 0; c < 3; c++)
            p[c*8 +: 8] = TONE_PICK[$urandom_range(0, TONE_PICKS - 1)];
        return p;
    endfunction

    // Offer one beat in bursts; returns just after the accepting edge
    task automatic send_beat(input logic [2:0] cmd, input logic [11:0] idx,
                             input logic [1:0] ch, input logic [31:0] val,
                             input logic [23:0] pix, input logic typed,
                             input logic [23:0] typed_out);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left = burst_left - 1;
        if (cmd == cmbr_pkg::CMD_PIXEL)
            pending_pixels.push_back(typed ? typed_out : backward_map(pix));
        else
            table_write(cmd, idx, ch, val);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, pix[23:16], pix[15:8], pix[7:0], val, ch, idx};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    // Drain the block, then let any load in flight settle
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_points(input logic [12:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pts_cfg   = v;
    endtask

    task automatic send_random_pixel();
        send_beat(cmbr_pkg::CMD_PIXEL, 12'($urandom), 2'($urandom), $urandom, pick_pixel(),
                  1'b0, '0);
    endtask

    // Mixed random beats: pixels, loads to any table, reserved commands
    task automatic send_random_beat();
        int          sel;
        logic [2:0]  cmd;
        logic [11:0] idx;
        logic [31:0] val;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            cmd = cmbr_pkg::CMD_PIXEL;
        else if (sel < 92)
            cmd = 3'($urandom_range(cmbr_pkg::CMD_POINT, cmbr_pkg::CMD_MATRIX));
        else
            cmd = $urandom_range(0, 1) ? CMD_RSVD_A : CMD_RSVD_B;
        idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0)
            val = $urandom;
        else if (cmd == cmbr_pkg::CMD_WEIGHT)
            val = $urandom_range(0, 1 << 17) - (1 << 16);
        else
            val = $urandom_range(0, 1 << 20);
        send_beat(cmd, idx, 2'($urandom), val, pick_pixel(), 1'b0, '0);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected pixel beat %h", m_tdata);
                err_count = err_count + 1;
            end
            else
            begin
                logic [23:0] want;
                want = pending_pixels.pop_front();
                if (m_tdata[7:0] !== want[7:0])
                begin
                    $error("red_out expected %0d got %0d", want[7:0], m_tdata[7:0]);
                    err_count = err_count + 1;
                end
                if (m_tdata[15:8] !== want[15:8])
                begin
                    $error("green_out expected %0d got %0d", want[15:8], m_tdata[15:8]);
                    err_count = err_count + 1;
                end
                if (m_tdata[23:16] !== want[23:16])
                begin
                    $error("blue_out expected %0d got %0d", want[23:16], m_tdata[23:16]);
                    err_count = err_count + 1;
                end
            end
        end
    end

    // Receiver: ready stretches, random stalls, and long hold-offs on request
    initial
    begin
        m_tready  <= 1'b0;
        hold_done = 0;
        hold_left = 0;
        pat_cnt   = 0;
        forever
        begin
            @(posedge clk);
            pat_cnt = pat_cnt + 1;
            if (hold_done != hold_asked)
            begin
                hold_done = hold_done + 1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if ((pat_cnt % 97) < 35)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        dir_rows = '{
            // saturated bias through an identity matrix
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd0, 32'h7FFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd1, 32'h7FFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd2, 32'h7FFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_PIXEL,  12'd0,   2'd0, 32'h0,        24'h000000, 1'b1, 24'hFFFFFF},
            '{cmbr_pkg::CMD_PIXEL,  12'hFFF, 2'd3, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
            // most negative matrix gain clamps red to zero
            '{cmbr_pkg::CMD_MATRIX, 12'd0,   2'd0, 32'h80000000, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_PIXEL,  12'd0,   2'd0, 32'h0,        24'h5A3C81, 1'b1, 24'hFFFF00},
            '{cmbr_pkg::CMD_MATRIX, 12'd0,   2'd0, 32'h00100000, 24'h000000, 1'b0, 24'h0},
            // most negative bias clamps red before the matrix
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd0, 32'h80000000, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_PIXEL,  12'd0,   2'd0, 32'h0,        24'hFFFFFF, 1'b1, 24'hFFFF00},
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd0, 32'h00010000, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd1, 32'h00020000, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_COEF,   12'd0,   2'd2, 32'h00000000, 24'h000000, 1'b0, 24'h0},
            // extreme words at the top indexes and at point zero
            '{cmbr_pkg::CMD_TONE,   12'd255, 2'd2, 32'h7FFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_POINT,  12'hFFF, 2'd2, 32'h80000000, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_WEIGHT, 12'hFFF, 2'd1, 32'h7FFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_POINT,  12'd0,   2'd0, 32'h80000000, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_WEIGHT, 12'd0,   2'd0, 32'h80000000, 24'h000000, 1'b0, 24'h0},
            // loads that must be dropped
            '{cmbr_pkg::CMD_POINT,  12'd1,   2'd3, 32'h0,        24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_TONE,   12'hFFF, 2'd0, 32'hFFFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_COEF,   12'd4,   2'd0, 32'hFFFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_MATRIX, 12'd3,   2'd1, 32'hFFFFFFFF, 24'h000000, 1'b0, 24'h0},
            '{CMD_RSVD_A,           12'hFFF, 2'd3, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0, 24'h0},
            '{CMD_RSVD_B,           12'd0,   2'd0, 32'h0,        24'h000000, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_PIXEL,  12'd0,   2'd0, 32'h0,        24'hFFFFFF, 1'b0, 24'h0},
            '{cmbr_pkg::CMD_PIXEL,  12'd0,   2'd0, 32'h0,        24'h000000, 1'b0, 24'h0}
        };
    end

    // Main sequence
    initial
    begin
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cycles     = 0;
        err_count  = 0;
        burst_left = 0;
        hold_asked = 0;
        pts_cfg    = cmbr_pkg::MAX_POINTS;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the reachable tone entries, gains, identity matrix, points and weights
        for (int t = 0; t < TONE_PICKS; t++)
            for (int c = 0; c < 3; c++)
                send_beat(cmbr_pkg::CMD_TONE, 12'(TONE_PICK[t]), 2'(c),
                          $urandom_range(0, (1 << 20) - 1), '0, 1'b0, '0);
        for (int c = 0; c < 3; c++)
        begin
            send_beat(cmbr_pkg::CMD_COEF, 12'd0, 2'(c), $urandom_range(0, 1 << 18),
                      '0, 1'b0, '0);
            for (int r = 1; r < cmbr_pkg::COEF_ROWS; r++)
                send_beat(cmbr_pkg::CMD_COEF, 12'(r), 2'(c), $urandom_range(0, 1 << 19),
                          '0, 1'b0, '0);
            for (int r = 0; r < cmbr_pkg::MAT_ROWS; r++)
                send_beat(cmbr_pkg::CMD_MATRIX, 12'(r), 2'(c),
                          (r == c) ? 32'h00100000 : 32'h0, '0, 1'b0, '0);
        end
        for (int p = 0; p < FILL_POINTS; p++)
            for (int c = 0; c < 3; c++)
            begin
                send_beat(cmbr_pkg::CMD_POINT, 12'(p), 2'(c),
                          $urandom_range(0, (1 << 20) - 1), '0, 1'b0, '0);
                send_beat(cmbr_pkg::CMD_WEIGHT, 12'(p), 2'(c),
                          $urandom_range(0, 1 << 17) - (1 << 16), '0, 1'b0, '0);
            end
        wait_idle();

        // Directed beats with the radial sum switched off
        set_points(13'd0);
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].ch, dir_rows[i].val,
                      dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].typed_out);
        wait_idle();

        // Random phases under different point counts
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_points(13'd1);
                1:       set_points(13'd2);
                2:       set_points(13'($urandom_range(1, FILL_POINTS)));
                default: set_points(13'd5);
            endcase
            if (ph == 1)
            begin
                // hold the output off while pixels keep arriving
                hold_asked = hold_asked + 1;
                repeat (4) send_random_pixel();
            end
            for (int i = 0; i < PHASE_BEATS; i++)
                send_random_beat();
            wait_idle();
        end

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
